@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the oscillator top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed");

// Check a consequent in the same cycle as its antecedent
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check a consequent in the cycle after its antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/lwo_pkg.sv @@
// ----------------------------------------------------------------------------
// lwo_pkg
// Shared codes, widths and control types of the looping wavetable oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package lwo_pkg;

	localparam int PHASE_W  = 32;
	localparam int SAMPLE_W = 16;
	localparam int FRAC_W   = 16;
	localparam int AMP_W    = 31;
	localparam int KIND_W   = 2;
	localparam int IB_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [IB_W-1:0] IB_MIN = 4'd1;
	localparam logic [IB_W-1:0] IB_MAX = 4'd12;

	// Transaction kinds
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GEN     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PHASE   = 3'd4;

	// Operand selection of the shared multiplier
	typedef enum logic [1:0] {
		MUL_LO,
		MUL_HI,
		MUL_AMP
	} mul_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     ram_we;
		logic     rd_next;
		logic     capture;
		logic     phase_clr;
		mul_sel_t mul_sel;
		logic     ld_acc;
		logic     ld_blend;
		logic     ld_out;
		logic     ld_end;
	} lwo_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic ended_now;
	} lwo_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/lwo_req_if.sv @@
// ----------------------------------------------------------------------------
// lwo_req_if
// Request channel: table writes, sample generation and phase restart.
// ----------------------------------------------------------------------------
`default_nettype none

interface lwo_req_if #(
	parameter int ADDR_W = 12
);
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [ADDR_W-1:0] table_addr;
	logic signed [15:0] table_data;
	logic [31:0]       phase_incr;
	logic [30:0]       amp;

	modport source (
		output valid, kind, table_addr, table_data, phase_incr, amp,
		input  ready
	);
	modport sink (
		input  valid, kind, table_addr, table_data, phase_incr, amp,
		output ready
	);
endinterface

`default_nettype wire

@@ hw/rtl/lwo_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lwo_rsp_if
// Response channel: one sample per generate transaction, interpolated or silenced.
// ----------------------------------------------------------------------------
`default_nettype none

interface lwo_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;
	logic               ended;

	modport source (
		output valid, sample_out, ended,
		input  ready
	);
	modport sink (
		input  valid, sample_out, ended,
		output ready
	);
endinterface

`default_nettype wire

@@ hw/rtl/lwo_ram.sv @@
// ----------------------------------------------------------------------------
// lwo_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lwo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/lwo_ctrl.sv @@
// ----------------------------------------------------------------------------
// lwo_ctrl
// Sequencer: accepts transactions, steps the datapath through interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module lwo_ctrl
	import lwo_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic [KIND_W-1:0] req_kind,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	input  wire lwo_status_t       status,
	output lwo_cmd_t               cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LO,
		S_HI,
		S_SCALE,
		S_END
	} state_t;

	state_t state_q;
	logic   accept;
	logic   slot_free;
	logic   out_load;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !rsp_valid || rsp_ready;
	assign out_load  = cmd.ld_out || cmd.ld_end;

	// Decode commands from state
	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = MUL_LO;
		cmd.ram_we    = accept && (req_kind == KIND_WRITE);
		cmd.phase_clr = accept && (req_kind == KIND_RESTART);
		cmd.capture   = accept && (req_kind == KIND_GEN);
		unique case (state_q)
			S_IDLE: begin
			end
			S_LO: begin
				cmd.rd_next = 1'b1;
				cmd.mul_sel = MUL_LO;
				cmd.ld_acc  = 1'b1;
			end
			S_HI: begin
				cmd.mul_sel  = MUL_HI;
				cmd.ld_blend = 1'b1;
			end
			S_SCALE: begin
				cmd.mul_sel = MUL_AMP;
				cmd.ld_out  = slot_free;
			end
			S_END: begin
				cmd.ld_end = slot_free;
			end
			default: begin
			end
		endcase
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_valid <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= status.ended_now ? S_END : S_LO;
					end
				end
				S_LO:    state_q <= S_HI;
				S_HI:    state_q <= S_SCALE;
				S_SCALE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_END: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lwo_datapath.sv @@
// ----------------------------------------------------------------------------
// lwo_datapath
// Phase accumulator, wave table, shared multiplier and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lwo_datapath
	import lwo_pkg::*;
#(
	parameter int TABLE_ADDR_BITS = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	input  wire logic [TABLE_ADDR_BITS-1:0] table_addr,
	input  wire logic [SAMPLE_W-1:0]        table_data,
	input  wire logic [PHASE_W-1:0]         phase_incr,
	input  wire logic [AMP_W-1:0]           amp,
	input  wire lwo_cmd_t                   cmd,
	output lwo_status_t                     status,
	output logic [SAMPLE_W-1:0]             sample_out,
	output logic                            ended
);

	localparam int DEPTH = 1 << TABLE_ADDR_BITS;

	logic                       loop_enable_q;
	logic [IB_W-1:0]            index_bits_q;
	logic [PHASE_W-1:0]         loop_end_q;
	logic [PHASE_W-1:0]         loop_length_q;
	logic [PHASE_W-1:0]         max_phase_q;
	logic [PHASE_W-1:0]         phase_q;
	logic [PHASE_W-1:0]         sum_q;
	logic [PHASE_W-1:0]         incr_q;
	logic [AMP_W-1:0]           amp_q;
	logic [FRAC_W-1:0]          frac_q;
	logic [TABLE_ADDR_BITS-1:0] idx_q;
	logic [SAMPLE_W-1:0]        acc_q;
	logic [SAMPLE_W-1:0]        blend_q;

	logic [IB_W-1:0]            ib_eff;
	logic [4:0]                 sh_amt;
	logic [PHASE_W-1:0]         shifted;
	logic [TABLE_ADDR_BITS-1:0] raddr;
	logic [SAMPLE_W-1:0]        rdata;
	logic signed [31:0]         mul_a;
	logic signed [16:0]         mul_b;
	logic signed [48:0]         prod;
	logic [SAMPLE_W-1:0]        prod_mid;

	// Clamp the index width to its legal range
	always_comb begin
		if (index_bits_q < IB_MIN) begin
			ib_eff = IB_MIN;
		end else if (index_bits_q > IB_MAX) begin
			ib_eff = IB_MAX;
		end else begin
			ib_eff = index_bits_q;
		end
	end

	// Split the phase into table index and fraction
	assign sh_amt  = 5'd16 - {1'b0, ib_eff};
	assign shifted = phase_q >> sh_amt;

	assign status.ended_now = !loop_enable_q && (phase_q >= max_phase_q);

	// Read the current entry on capture, its neighbour in state S_LO
	assign raddr = cmd.rd_next ? idx_q + 1'b1 : shifted[16 +: TABLE_ADDR_BITS];

	lwo_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (table_addr),
		.wdata (table_data),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Shared multiplier operand selection
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_LO: begin
				mul_a = signed'({16'd0, ~frac_q});
				mul_b = signed'({rdata[SAMPLE_W-1], rdata});
			end
			MUL_HI: begin
				mul_a = signed'({16'd0, frac_q});
				mul_b = signed'({rdata[SAMPLE_W-1], rdata});
			end
			MUL_AMP: begin
				mul_a = signed'({1'b0, amp_q});
				mul_b = signed'({blend_q[SAMPLE_W-1], blend_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Floor of product over 2^16, low 16 bits kept
	assign prod     = mul_a * mul_b;
	assign prod_mid = prod[31:16];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_enable_q <= 1'b0;
			index_bits_q  <= IB_MAX;
			loop_end_q    <= '0;
			loop_length_q <= '0;
			max_phase_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOOP_ENABLE: loop_enable_q <= cfg_data[0];
				CFG_INDEX_BITS:  index_bits_q  <= cfg_data[IB_W-1:0];
				CFG_LOOP_END:    loop_end_q    <= cfg_data;
				CFG_LOOP_LENGTH: loop_length_q <= cfg_data;
				CFG_MAX_PHASE:   max_phase_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Phase accumulator: clear, or advance after a sample and wrap in loop mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.phase_clr) begin
			phase_q <= '0;
		end else if (cmd.ld_out) begin
			if (loop_enable_q && (sum_q >= loop_end_q)) begin
				phase_q <= sum_q - loop_length_q;
			end else begin
				phase_q <= sum_q;
			end
		end
	end

	// Capture operands and run the interpolation steps
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			incr_q <= phase_incr;
			amp_q  <= amp;
			frac_q <= shifted[FRAC_W-1:0];
			idx_q  <= shifted[16 +: TABLE_ADDR_BITS];
		end
		if (cmd.ld_acc) begin
			acc_q <= prod_mid;
		end
		if (cmd.ld_blend) begin
			blend_q <= acc_q + prod_mid;
			sum_q   <= phase_q + incr_q;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			sample_out <= prod_mid;
			ended      <= 1'b0;
		end else if (cmd.ld_end) begin
			sample_out <= '0;
			ended      <= 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/looping_wavetable_oscillator.sv @@
// ----------------------------------------------------------------------------
// looping_wavetable_oscillator
// Wavetable oscillator with linear interpolation, loop and one-shot playback.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  --------+-----+---------------------------------------------------------
//  req     | in  | kind, table_addr, table_data, phase_incr, amp
//  rsp     | out | sample_out, ended (one per generate request)
//  cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// A generate request steps through accept with the first table read, the
// neighbour read, the blend, then scaling into the output register. The
// single table read port and the one shared multiplier force these steps.
// Write, restart, unknown kinds end on acceptance; a silenced one-shot
// sample takes S_END. A full output register stalls scaling or S_END until
// rsp is taken; req is held off (ready low) then. No clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module looping_wavetable_oscillator
	import lwo_pkg::*;
#(
	parameter int TABLE_ADDR_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	lwo_req_if.sink                    req,
	lwo_rsp_if.source                  rsp
);

	lwo_cmd_t    ctl_cmd;
	lwo_status_t dp_status;

	lwo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_kind  (req.kind),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (dp_status),
		.cmd       (ctl_cmd)
	);

	lwo_datapath #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.table_addr (req.table_addr),
		.table_data (req.table_data),
		.phase_incr (req.phase_incr),
		.amp        (req.amp),
		.cmd        (ctl_cmd),
		.status     (dp_status),
		.sample_out (rsp.sample_out),
		.ended      (rsp.ended)
	);

	// A silenced sample carries zero
	`ASSERT_IMPLIES(a_ended_silent, clk, arst_n, rsp.valid && rsp.ended, rsp.sample_out == '0)
	// Table writes only come from an accepted write request
	`ASSERT_IMPLIES(a_write_src, clk, arst_n, ctl_cmd.ram_we, req.valid && req.ready && (req.kind == KIND_WRITE))
	// A generate request keeps the block busy in the following cycle
	`ASSERT_NEXT(a_gen_busy, clk, arst_n, req.valid && req.ready && (req.kind == KIND_GEN), !req.ready)
	// Only one result source loads per cycle
	`ASSERT_ALWAYS(a_one_load, clk, arst_n, !(ctl_cmd.ld_out && ctl_cmd.ld_end))

endmodule

`default_nettype wire

@@ sim/looping_wavetable_oscillator_tb.sv @@
// ----------------------------------------------------------------------------
// looping_wavetable_oscillator_tb
// Self-checking bench for the wavetable oscillator. Request transactions are
// mirrored into a local oscillator predictor as they are accepted, which
// queues the expected samples. Each response is compared in order against
// that queue. Directed tests cover table extremes, index width limits, loop
// jumps, one-shot end and output back-pressure. Randomised phases under
// varied register settings and random idling on both channels follow.
// ----------------------------------------------------------------------------
module looping_wavetable_oscillator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lwo_pkg::*;

	localparam int CLK_PERIOD      = 4;
	localparam int RESET_CYCLES    = 12;
	localparam int TABLE_ADDR_BITS = 12;
	localparam int TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PRESSURE_HOLD   = 300;
	localparam int RANDOM_ITEMS    = 1350;
	localparam int RANDOM_PHASES   = 6;

	// Unused request code, ignored by the block
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       ended;
	} sample_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lwo_req_if #(.ADDR_W(TABLE_ADDR_BITS)) req ();
	lwo_rsp_if rsp ();

	// Oscillator predictor state
	bit                         osc_loop_en    = 1'b0;
	logic [IB_W-1:0]            osc_index_bits = IB_MAX;
	logic [PHASE_W-1:0]         osc_loop_end   = '0;
	logic [PHASE_W-1:0]         osc_loop_len   = '0;
	logic [PHASE_W-1:0]         osc_max_phase  = '0;
	logic [PHASE_W-1:0]         osc_phase      = '0;
	logic signed [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
	bit                         wave_written [TABLE_DEPTH];

	sample_t pending_samples [$];
	int      errors     = 0;
	bit      idling_on  = 1'b1;
	int      sink_hold  = 0;
	int      sent_count = 0;

	looping_wavetable_oscillator #(
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Clamp the index width to the range the datapath supports
	function automatic int index_width();
		if (osc_index_bits < IB_MIN) return int'(IB_MIN);
		if (osc_index_bits > IB_MAX) return int'(IB_MAX);
		return int'(osc_index_bits);
	endfunction

	function automatic int table_index(logic [PHASE_W-1:0] ph);
		return int'(ph >> (PHASE_W - index_width())) & (TABLE_DEPTH - 1);
	endfunction

	// Blend two neighbouring entries, then scale by the gain
	function automatic logic signed [SAMPLE_W-1:0] interpolate_sample(
		logic [PHASE_W-1:0] ph, logic [AMP_W-1:0] gain);
		int                         idx;
		longint                     frac, lo, hi, mix, scaled;
		logic signed [SAMPLE_W-1:0] mix16;
		idx    = table_index(ph);
		frac   = longint'((ph >> (FRAC_W - index_width())) & 32'h0000_FFFF);
		lo     = longint'(wave_mem[idx]);
		hi     = longint'(wave_mem[(idx + 1) & (TABLE_DEPTH - 1)]);
		mix    = ((frac * hi) >>> 16) + (((65535 - frac) * lo) >>> 16);
		mix16  = mix[15:0];
		scaled = (longint'(gain) * longint'(mix16)) >>> 16;
		return scaled[15:0];
	endfunction

	// Advance the predictor by one accepted request transaction
	function automatic void predict_transaction(logic [KIND_W-1:0] kind,
		logic [TABLE_ADDR_BITS-1:0] addr, logic signed [SAMPLE_W-1:0] data,
		logic [PHASE_W-1:0] incr, logic [AMP_W-1:0] gain);
		sample_t s;
		case (kind)
		KIND_WRITE: begin
			wave_mem[addr]     = data;
			wave_written[addr] = 1'b1;
		end
		KIND_RESTART: begin
			osc_phase = '0;
		end
		KIND_GEN: begin
			s.sample = '0;
			s.ended  = 1'b0;
			if (!osc_loop_en && osc_phase >= osc_max_phase) begin
				s.ended = 1'b1;
			end else begin
				s.sample  = interpolate_sample(osc_phase, gain);
				osc_phase = osc_phase + incr;
				if (osc_loop_en && osc_phase >= osc_loop_end)
					osc_phase = osc_phase - osc_loop_len;
			end
			pending_samples.push_back(s);
		end
		default: ;
		endcase
	endfunction

	// Offer one request and hold it until the block takes it
	task automatic send_req(input logic [KIND_W-1:0] kind,
		input logic [TABLE_ADDR_BITS-1:0] addr, input logic signed [SAMPLE_W-1:0] data,
		input logic [PHASE_W-1:0] incr, input logic [AMP_W-1:0] gain);
		int gap;
		if (idling_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.kind       <= kind;
		req.table_addr <= addr;
		req.table_data <= data;
		req.phase_incr <= incr;
		req.amp        <= gain;
		do @(posedge clk); while (req.ready !== 1'b1);
		predict_transaction(kind, addr, data, incr, gain);
		sent_count++;
	endtask

	// Generate one sample, loading any table entry it would read unwritten
	task automatic gen_sample(input logic [PHASE_W-1:0] incr, input logic [AMP_W-1:0] gain);
		int idx, nxt;
		if (osc_loop_en || osc_phase < osc_max_phase) begin
			idx = table_index(osc_phase);
			nxt = (idx + 1) & (TABLE_DEPTH - 1);
			if (!wave_written[idx])
				send_req(KIND_WRITE, 12'(idx), 16'($urandom), $urandom, 31'($urandom));
			if (!wave_written[nxt])
				send_req(KIND_WRITE, 12'(nxt), 16'($urandom), $urandom, 31'($urandom));
		end
		send_req(KIND_GEN, 12'($urandom), 16'($urandom), incr, gain);
	endtask

	// Drop valid and let the block drain before touching registers
	task automatic wait_idle();
		req.valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write every register in turn, then mirror them into the predictor
	task automatic program_regs(input bit le, input logic [IB_W-1:0] ib,
		input logic [PHASE_W-1:0] lend, input logic [PHASE_W-1:0] llen,
		input logic [PHASE_W-1:0] maxp);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LOOP_ENABLE;
		cfg_data  <= 32'(le);
		@(posedge clk);
		cfg_index <= CFG_INDEX_BITS;
		cfg_data  <= 32'(ib);
		@(posedge clk);
		cfg_index <= CFG_LOOP_END;
		cfg_data  <= lend;
		@(posedge clk);
		cfg_index <= CFG_LOOP_LENGTH;
		cfg_data  <= llen;
		@(posedge clk);
		cfg_index <= CFG_MAX_PHASE;
		cfg_data  <= maxp;
		@(posedge clk);
		cfg_we <= 1'b0;
		osc_loop_en    = le;
		osc_index_bits = ib;
		osc_loop_end   = lend;
		osc_loop_len   = llen;
		osc_max_phase  = maxp;
	endtask

	// Reset registers leave one-shot mode with a zero end: all silent
	task automatic test_reset_defaults();
		gen_sample($urandom, 31'($urandom));
		send_req(KIND_NONE, 12'($urandom), 16'($urandom), $urandom, 31'($urandom));
		send_req(KIND_RESTART, 12'($urandom), 16'($urandom), $urandom, 31'($urandom));
		gen_sample($urandom, 31'($urandom));
	endtask

	// Full-scale samples, top entry wrapping to entry zero, fraction limits
	task automatic test_table_extremes();
		wait_idle();
		program_regs(1'b1, IB_MAX, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_req(KIND_WRITE, 12'd0, 16'sh7FFF, 32'h0, 31'h0);
		send_req(KIND_WRITE, 12'd1, 16'sh8000, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
		send_req(KIND_WRITE, 12'd4095, 16'sh8000, 32'h0, 31'h0);
		send_req(KIND_WRITE, 12'd4094, 16'sh7FFF, 32'h0, 31'h0);
		send_req(KIND_RESTART, 12'hFFF, 16'shFFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
		gen_sample(32'hFFE0_0000, 31'h7FFF_FFFF);
		gen_sample(32'h0010_0000, 31'h7FFF_FFFF);
		gen_sample(32'h000F_FFF0, 31'd1);
		gen_sample(32'h0, 31'h0);
		gen_sample(32'h0000_000F, 31'h4000_0000);
		gen_sample(32'h1, 31'h7FFF_FFFF);
	endtask

	// Index widths of zero and above the maximum clamp to the limits
	task automatic test_index_width_limits();
		wait_idle();
		program_regs(1'b1, 4'd0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		gen_sample(32'h8000_0000, 31'h7FFF_FFFF);
		gen_sample(32'h4000_0000, 31'h1234_5678);
		wait_idle();
		program_regs(1'b1, 4'd15, 32'hFFFF_FFFF, 32'h0, 32'h0);
		gen_sample(32'h0123_4567, 31'h7FFF_FFFF);
		gen_sample(32'hFEDC_BA98, 31'h0000_FFFF);
	endtask

	// Phase passes the loop end and jumps back by the loop length
	task automatic test_loop_jump();
		int n;
		wait_idle();
		program_regs(1'b1, 4'd4, 32'h8000_0000, 32'h6000_0000, 32'h0);
		send_req(KIND_RESTART, '0, '0, '0, '0);
		for (n = 0; n < 6; n++)
			gen_sample(32'h1C00_0000, 31'($urandom));
	endtask

	// One-shot playback goes silent at the end and holds there until restart
	task automatic test_one_shot_end();
		int n;
		wait_idle();
		program_regs(1'b0, 4'd8, 32'h0, 32'h0, 32'h0300_0000);
		send_req(KIND_RESTART, '0, '0, '0, '0);
		for (n = 0; n < 5; n++)
			gen_sample(32'h0100_0000, 31'($urandom));
		send_req(KIND_RESTART, '0, '0, '0, '0);
		gen_sample(32'h0080_0000, 31'($urandom));
	endtask

	// Hold the response side off while requests keep coming
	task automatic test_output_backpressure();
		int n;
		wait_idle();
		program_regs(1'b1, 4'd6, 32'hC000_0000, 32'h8000_0000, 32'h0);
		idling_on = 1'b0;
		sink_hold = PRESSURE_HOLD;
		for (n = 0; n < 40; n++)
			gen_sample($urandom >> 4, 31'($urandom));
		idling_on = 1'b1;
	endtask

	// Random traffic under several register settings
	task automatic test_random_traffic();
		int          phase_no, start, pick, ib;
		logic [31:0] lend, llen, maxp;
		for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
			wait_idle();
			idling_on = (phase_no != RANDOM_PHASES - 1) && (phase_no != 2);
			ib   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
			lend = $urandom;
			llen = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, lend);
			maxp = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : $urandom;
			program_regs(1'($urandom_range(0, 1)), 4'(ib), lend, llen, maxp);
			// every transaction sent counts, table preloads included
			start = sent_count;
			while (sent_count - start < RANDOM_ITEMS / RANDOM_PHASES) begin
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					send_req(KIND_WRITE, 12'($urandom), 16'($urandom), $urandom,
						31'($urandom));
				end else if (pick < 20) begin
					send_req(KIND_RESTART, 12'($urandom), 16'($urandom), $urandom,
						31'($urandom));
				end else if (pick < 24) begin
					send_req(KIND_NONE, 12'($urandom), 16'($urandom), $urandom,
						31'($urandom));
				end else begin
					gen_sample($urandom >> $urandom_range(0, 12), 31'($urandom));
				end
			end
		end
	endtask

	// Drive the response ready: long holds on request, random short stalls
	initial begin : sink_ready
		int stall_left;
		stall_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				stall_left = sink_hold - 1;
				sink_hold  = 0;
				rsp.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 11);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Compare each response transaction with the oldest expected sample
	always @(posedge clk) begin : check_sample
		sample_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_samples.size() == 0) begin
				$error("sample_out: none expected, got %0d (ended %0b)",
					rsp.sample_out, rsp.ended);
				errors++;
			end else begin
				want = pending_samples.pop_front();
				if (rsp.sample_out !== want.sample) begin
					$error("sample_out: expected %0d, got %0d", want.sample, rsp.sample_out);
					errors++;
				end
				if (rsp.ended !== want.ended) begin
					$error("ended: expected %0b, got %0b", want.ended, rsp.ended);
					errors++;
				end
			end
		end
	end

	// Abort when neither channel moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid === 1'b1 && req.ready === 1'b1) ||
			    (rsp.valid === 1'b1 && rsp.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : run_tests
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= CFG_LOOP_ENABLE;
		cfg_data       <= '0;
		req.valid      <= 1'b0;
		req.kind       <= KIND_WRITE;
		req.table_addr <= '0;
		req.table_data <= '0;
		req.phase_incr <= '0;
		req.amp        <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_table_extremes();
		test_index_width_limits();
		test_loop_jump();
		test_one_shot_end();
		test_output_backpressure();
		test_random_traffic();

		wait_idle();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lwo_pkg.sv
hw/rtl/lwo_req_if.sv
hw/rtl/lwo_rsp_if.sv
hw/rtl/lwo_ram.sv
hw/rtl/lwo_ctrl.sv
hw/rtl/lwo_datapath.sv
hw/rtl/looping_wavetable_oscillator.sv
sim/looping_wavetable_oscillator_tb.sv
